[design/hte_pkg.sv]
package hte_pkg;

   localparam int CODE_W  = 32;
   localparam int LEN_W   = 6;
   localparam int BYTE_W  = 8;
   localparam int ACC_W   = CODE_W + BYTE_W;
   localparam int TOTAL_W = 7;
   localparam int LEFT_W  = 3;
   localparam int CNT_W   = 3;

   typedef enum logic [1:0] {
      ACT_LOAD   = 2'd0,
      ACT_ENCODE = 2'd1,
      ACT_FLUSH  = 2'd2
   } action_type;

   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] code;
   } entry_type;

   typedef struct packed {
      logic      wr_en;
      logic      rd_en;
      entry_type entry;
   } tbl_req_type;

endpackage

[design/hte_table.sv]
module hte_table #(
   parameter int SYMBOL_COUNT = 256,
   parameter int IDX_W        = $clog2(SYMBOL_COUNT)
) (
   input  logic                clock,
   input  logic                reset,
   input  hte_pkg::tbl_req_type req,
   input  logic [IDX_W-1:0]    addr,
   output hte_pkg::entry_type  rd_entry,
   output logic                rd_valid
);

   hte_pkg::entry_type mem_ff [SYMBOL_COUNT];
   logic [SYMBOL_COUNT-1:0] valid_ff;
   hte_pkg::entry_type      rd_entry_ff;
   logic                    rd_valid_ff;

   // entry storage, synchronous read
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem_ff[addr] <= req.entry;
      end
      if (req.rd_en) begin
         rd_entry_ff <= mem_ff[addr];
      end
   end

   // per-entry valid bits stand in for the reset clear
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (req.wr_en) begin
            valid_ff[addr] <= 1'b1;
         end
         if (req.rd_en) begin
            rd_valid_ff <= valid_ff[addr];
         end
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_valid = rd_valid_ff;

endmodule

[design/huffman_table_encoder.sv]
// Table-driven Huffman bit packer. Load beats write a code and length into a
// SYMBOL_COUNT-entry table (length saturated to min(MAX_CODE_LENGTH, 32), bits
// above it masked); encode beats read it back through the registered table
// read and merge the code, MSB first, behind the pending bits; flush beats pad
// the pending byte with zeros. Output bytes carry the earliest bit in bit 7,
// tlast on the final byte of each input beat. Input accepts one beat per cycle
// while each beat emits at most one byte and the output is not stalled; more
// bytes hold the input while they leave through the single byte-wide output
// register. The table is cleared at reset through per-entry valid bits: no
// clearing pass, ready the cycle after reset.
module huffman_table_encoder #(
   parameter int SYMBOL_COUNT    = 256,
   parameter int MAX_CODE_LENGTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // symbol[7:0], code_value[39:8], code_length[45:40]
   input  logic [1:0]  req_tuser,   // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte[7:0]
   output logic        rsp_tlast
);

   localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam int CAP   = (MAX_CODE_LENGTH < hte_pkg::CODE_W) ? MAX_CODE_LENGTH
                                                              : hte_pkg::CODE_W;
   localparam int AW    = hte_pkg::ACC_W;
   localparam int BW    = hte_pkg::BYTE_W;

   hte_pkg::action_type           action;
   logic [7:0]                    symbol;
   logic [hte_pkg::CODE_W-1:0]    code_value;
   logic [hte_pkg::LEN_W-1:0]     code_length;
   logic [hte_pkg::LEN_W-1:0]     len_sat;
   logic                          in_range;
   logic                          accept;

   hte_pkg::tbl_req_type          tbl_req;
   hte_pkg::entry_type            rd_entry;
   logic                          rd_valid;

   logic                          s1_valid_ff, s1_valid_in;
   hte_pkg::action_type           s1_action_ff;
   logic                          s1_hit_ff;

   logic [AW-1:0]                 acc_ff, acc_in;
   logic [hte_pkg::LEFT_W-1:0]    left_ff, left_in;
   logic [hte_pkg::CNT_W-1:0]     pcount_ff, pcount_in;
   logic                          rsp_tvalid_ff, rsp_tvalid_in;
   logic [BW-1:0]                 rsp_tdata_ff, rsp_tdata_in;
   logic                          rsp_tlast_ff, rsp_tlast_in;

   logic                          hit;
   logic [hte_pkg::LEN_W-1:0]     len;
   logic [hte_pkg::CODE_W-1:0]    code;
   logic                          emit_fire;
   logic                          absorb;
   logic [AW-1:0]                 base_acc;
   logic [hte_pkg::LEFT_W-1:0]    base_left;
   logic [BW-1:0]                 pend;
   logic [hte_pkg::TOTAL_W-1:0]   total;
   logic [hte_pkg::TOTAL_W-1:0]   shamt;
   logic [AW-1:0]                 merged;

   assign action      = hte_pkg::action_type'(req_tuser);
   assign symbol      = req_tdata[7:0];
   assign code_value  = req_tdata[39:8];
   assign code_length = req_tdata[45:40];
   assign in_range    = {1'b0, symbol} < 9'(SYMBOL_COUNT);
   assign accept      = req_tvalid && req_tready;
   assign len_sat     = (code_length > hte_pkg::LEN_W'(CAP)) ? hte_pkg::LEN_W'(CAP)
                                                             : code_length;

   always_comb begin
      tbl_req.wr_en      = accept && (action == hte_pkg::ACT_LOAD) && in_range;
      tbl_req.rd_en      = accept && (action == hte_pkg::ACT_ENCODE);
      tbl_req.entry.len  = len_sat;
      tbl_req.entry.code = code_value & ~({hte_pkg::CODE_W{1'b1}} << len_sat);
   end

   hte_table #(
      .SYMBOL_COUNT (SYMBOL_COUNT),
      .IDX_W        (IDX_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .req      (tbl_req),
      .addr     (symbol[IDX_W-1:0]),
      .rd_entry (rd_entry),
      .rd_valid (rd_valid)
   );

   // stage 1: table data arrives
   assign hit  = s1_hit_ff && rd_valid;
   assign len  = hit ? rd_entry.len  : '0;
   assign code = hit ? rd_entry.code : '0;

   assign emit_fire  = (left_ff != '0) && (!rsp_tvalid_ff || rsp_tready);
   assign absorb     = s1_valid_ff &&
                       ((left_ff == '0) || ((left_ff == hte_pkg::LEFT_W'(1)) && emit_fire));
   assign req_tready = !s1_valid_ff || absorb;

   assign base_acc  = emit_fire ? {acc_ff[AW-BW-1:0], {BW{1'b0}}} : acc_ff;
   assign base_left = emit_fire ? left_ff - hte_pkg::LEFT_W'(1) : left_ff;
   assign pend      = base_acc[AW-1:AW-BW];
   assign total     = hte_pkg::TOTAL_W'(pcount_ff) + hte_pkg::TOTAL_W'(len);
   assign shamt     = hte_pkg::TOTAL_W'(AW) - total;
   assign merged    = {pend, {hte_pkg::CODE_W{1'b0}}} | (AW'(code) << shamt);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (absorb) begin
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end

      acc_in    = base_acc;
      left_in   = base_left;
      pcount_in = pcount_ff;
      if (absorb) begin
         case (s1_action_ff)
            hte_pkg::ACT_ENCODE: begin
               acc_in    = merged;
               left_in   = hte_pkg::LEFT_W'(total >> 3);
               pcount_in = total[hte_pkg::CNT_W-1:0];
            end
            hte_pkg::ACT_FLUSH: begin
               if (pcount_ff != '0) begin
                  acc_in    = {pend, {hte_pkg::CODE_W{1'b0}}};
                  left_in   = hte_pkg::LEFT_W'(1);
                  pcount_in = '0;
               end
            end
            default: begin
            end
         endcase
      end

      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      if (emit_fire) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = acc_ff[AW-1:AW-BW];
         rsp_tlast_in  = (left_ff == hte_pkg::LEFT_W'(1));
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         acc_ff        <= '0;
         left_ff       <= '0;
         pcount_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         acc_ff        <= acc_in;
         left_ff       <= left_in;
         pcount_ff     <= pcount_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_action_ff <= action;
         s1_hit_ff    <= in_range;
      end
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

[design/hte_checker.sv]
module hte_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast
);

   // nothing in flight right after reset
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output beat right after reset");

   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("input not ready right after reset");

   // bytes of one input beat leave back to back
   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("gap inside a multi-byte burst");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled output beat changed");

endmodule

bind huffman_table_encoder hte_checker u_hte_checker (.*);

[sim/huffman_table_encoder_test.sv]
`timescale 1ns / 1ps

module huffman_table_encoder_test;

   localparam logic [1:0] ACT_SPARE = 2'd3;
   localparam int LEN_CAP = 32;
   localparam int RANDOM_BEATS = 200;
   localparam int EXP_DEPTH = 64;
   localparam int ROW_DEPTH = 32;

   typedef struct {
      logic [1:0]  action;
      logic [7:0]  symbol;
      logic [31:0] code;
      logic [5:0]  length;
      int          n_typed;      // -1: expected bytes come from the predictor
      logic [39:0] typed_bytes;  // first byte in [7:0]
   } stim_row_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } packed_byte_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // symbol[7:0], code_value[39:8], code_length[45:40]
   logic [1:0]  req_tuser;   // action[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // out_byte[7:0]
   logic        rsp_tlast;

   logic [31:0] tab_code [256];
   logic [5:0]  tab_len [256];
   logic [7:0]  acc_bits;
   int          acc_cnt;

   stim_row_type    directed_rows [ROW_DEPTH];
   int              n_directed;
   packed_byte_type model_bytes [5];
   int              model_n;
   packed_byte_type exp_ring [EXP_DEPTH];
   int              exp_wr;
   int              exp_rd;

   int  fail_count;
   int  bytes_checked;
   int  n_load, n_encode, n_flush, n_spare;
   bit  no_idle;
   bit  sink_busy;
   int  sink_left;

   huffman_table_encoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic add_model_byte(input packed_byte_type v);
      model_bytes[model_n] = v;
      model_n++;
   endtask

   task automatic add_expected(input packed_byte_type v);
      exp_ring[exp_wr % EXP_DEPTH] = v;
      exp_wr++;
   endtask

   // bit packer: updates table and pending byte, leaves produced bytes in model_bytes
   task automatic pack_beat(input stim_row_type b);
      int n;
      model_n = 0;
      case (b.action)
         hte_pkg::ACT_LOAD: begin
            n = (b.length > LEN_CAP) ? LEN_CAP : b.length;
            tab_len[b.symbol] = n[5:0];
            tab_code[b.symbol] = b.code & ~(32'hFFFF_FFFF << n);
            n_load++;
         end
         hte_pkg::ACT_ENCODE: begin
            for (int i = tab_len[b.symbol]; i > 0; i--) begin
               acc_bits[7 - acc_cnt] = tab_code[b.symbol][i - 1];
               acc_cnt++;
               if (acc_cnt == 8) begin
                  add_model_byte({acc_bits, 1'b0});
                  acc_bits = '0;
                  acc_cnt = 0;
               end
            end
            if (model_n > 0) model_bytes[model_n - 1].last = 1'b1;
            n_encode++;
         end
         hte_pkg::ACT_FLUSH: begin
            if (acc_cnt != 0) begin
               add_model_byte({acc_bits, 1'b1});
               acc_bits = '0;
               acc_cnt = 0;
            end
            n_flush++;
         end
         default: n_spare++;
      endcase
   endtask

   task automatic add_row(input logic [1:0] act, input logic [7:0] sym, input logic [31:0] code,
                          input logic [5:0] len, input int n, input logic [39:0] bytes);
      stim_row_type r;
      r.action = act;
      r.symbol = sym;
      r.code = code;
      r.length = len;
      r.n_typed = n;
      r.typed_bytes = bytes;
      directed_rows[n_directed] = r;
      n_directed++;
   endtask

   // entered and left at a falling edge
   task automatic send_beat(input stim_row_type b);
      int gap;
      gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= b.action;
      req_tdata <= {2'b00, b.length, b.code, b.symbol};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pack_beat(b);
      if (b.n_typed < 0) begin
         for (int i = 0; i < model_n; i++) add_expected(model_bytes[i]);
      end else begin
         for (int i = 0; i < b.n_typed; i++)
            add_expected({b.typed_bytes[8*i +: 8], i == b.n_typed - 1});
      end
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (sink_left == 0) begin
         sink_busy = !sink_busy && !no_idle && ($urandom_range(0, 2) == 0);
         sink_left = sink_busy ? pick_gap() : $urandom_range(1, 8);
      end else begin
         sink_left--;
      end
      rsp_tready <= !sink_busy;
   end

   always @(posedge clock) begin
      packed_byte_type exp_b;
      if (!reset && rsp_tvalid && rsp_tready) begin
         bytes_checked++;
         if (exp_wr == exp_rd) begin
            $error("unexpected beat: out_byte %02h last %0b", rsp_tdata, rsp_tlast);
            fail_count++;
         end else begin
            exp_b = exp_ring[exp_rd % EXP_DEPTH];
            exp_rd++;
            if (rsp_tdata !== exp_b.data) begin
               $error("out_byte: expected %02h, got %02h", exp_b.data, rsp_tdata);
               fail_count++;
            end
            if (rsp_tlast !== exp_b.last) begin
               $error("last: expected %0b, got %0b", exp_b.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("timeout: %0d bytes still expected", exp_wr - exp_rd);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      stim_row_type b;
      logic [7:0]   pool [8];
      int           rand_count;
      int           r;

      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = hte_pkg::ACT_LOAD;
      rsp_tready = 1'b0;
      sink_busy = 1'b0;
      sink_left = 0;
      no_idle = 1'b0;
      fail_count = 0;
      bytes_checked = 0;
      n_load = 0;
      n_encode = 0;
      n_flush = 0;
      n_spare = 0;
      n_directed = 0;
      model_n = 0;
      exp_wr = 0;
      exp_rd = 0;
      acc_bits = '0;
      acc_cnt = 0;
      foreach (tab_len[i]) begin
         tab_len[i] = '0;
         tab_code[i] = '0;
      end

      // empty table, empty accumulator, spare action
      add_row(hte_pkg::ACT_ENCODE, 8'h00, 32'h0, 6'd0, 0, 40'h0);
      add_row(hte_pkg::ACT_FLUSH, 8'h00, 32'h0, 6'd0, 0, 40'h0);
      add_row(ACT_SPARE, 8'hFF, 32'hFFFF_FFFF, 6'd63, 0, 40'h0);
      // zero-length code
      add_row(hte_pkg::ACT_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd0, 0, 40'h0);
      add_row(hte_pkg::ACT_ENCODE, 8'h00, 32'h0, 6'd0, 0, 40'h0);
      // overlong length saturates to 32
      add_row(hte_pkg::ACT_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd63, 0, 40'h0);
      add_row(hte_pkg::ACT_ENCODE, 8'hFF, 32'h0, 6'd0, 4, 40'h00_FF_FF_FF_FF);
      // bits above length masked; single bit then flush pads with zeros
      add_row(hte_pkg::ACT_LOAD, 8'h80, 32'hFFFF_FFFF, 6'd1, 0, 40'h0);
      add_row(hte_pkg::ACT_ENCODE, 8'h80, 32'h0, 6'd0, 0, 40'h0);
      add_row(hte_pkg::ACT_FLUSH, 8'h00, 32'h0, 6'd0, 1, 40'h80);
      add_row(hte_pkg::ACT_LOAD, 8'h01, 32'hFFFF_FFA5, 6'd8, 0, 40'h0);
      add_row(hte_pkg::ACT_ENCODE, 8'h01, 32'h0, 6'd0, 1, 40'hA5);
      add_row(hte_pkg::ACT_LOAD, 8'h02, 32'h0, 6'd32, 0, 40'h0);
      add_row(hte_pkg::ACT_ENCODE, 8'h02, 32'h0, 6'd0, 4, 40'h0);
      // unaligned packing across byte boundaries
      add_row(hte_pkg::ACT_LOAD, 8'h03, 32'h5, 6'd3, -1, 40'h0);
      add_row(hte_pkg::ACT_ENCODE, 8'h03, 32'h0, 6'd0, -1, 40'h0);
      add_row(hte_pkg::ACT_ENCODE, 8'h03, 32'h0, 6'd0, -1, 40'h0);
      add_row(hte_pkg::ACT_ENCODE, 8'h03, 32'h0, 6'd0, -1, 40'h0);
      add_row(hte_pkg::ACT_ENCODE, 8'hFF, 32'h0, 6'd0, -1, 40'h0);
      add_row(hte_pkg::ACT_FLUSH, 8'h00, 32'h0, 6'd0, -1, 40'h0);
      add_row(hte_pkg::ACT_LOAD, 8'h10, 32'h1, 6'd32, 0, 40'h0);
      add_row(hte_pkg::ACT_LOAD, 8'h11, 32'h8000_0000, 6'd32, 0, 40'h0);
      add_row(hte_pkg::ACT_LOAD, 8'h12, 32'hDEAD_BEEF, 6'd33, 0, 40'h0);
      add_row(hte_pkg::ACT_ENCODE, 8'h10, 32'h0, 6'd0, 4, 40'h00_01_00_00_00);
      add_row(hte_pkg::ACT_ENCODE, 8'h11, 32'h0, 6'd0, 4, 40'h00_00_00_00_80);
      add_row(hte_pkg::ACT_ENCODE, 8'h12, 32'h0, 6'd0, 4, 40'h00_EF_BE_AD_DE);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < n_directed; i++) send_beat(directed_rows[i]);

      foreach (pool[i]) pool[i] = $urandom_range(0, 255);
      rand_count = 0;
      while (rand_count < RANDOM_BEATS) begin
         no_idle = ((rand_count / 40) % 3 == 2);
         b.code = $urandom;
         b.length = $urandom_range(0, 63);
         b.symbol = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 7)]
                                                 : 8'($urandom_range(0, 255));
         b.n_typed = -1;
         b.typed_bytes = '0;
         r = $urandom_range(0, 99);
         if (r < 22) begin
            b.action = hte_pkg::ACT_LOAD;
            r = $urandom_range(0, 99);
            if (r < 40) b.length = $urandom_range(1, 12);
            else if (r < 75) b.length = $urandom_range(13, 32);
            else if (r < 85) b.length = '0;
         end else if (r < 85) begin
            b.action = hte_pkg::ACT_ENCODE;
         end else if (r < 97) begin
            b.action = hte_pkg::ACT_FLUSH;
         end else begin
            b.action = ACT_SPARE;
         end
         send_beat(b);
         if (b.action != ACT_SPARE) rand_count++;
      end
      req_tvalid <= 1'b0;

      while (exp_rd != exp_wr) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("covered %0d directed and %0d random beats: %0d loads, %0d encodes, %0d flushes",
               n_directed, rand_count, n_load, n_encode, n_flush);
      $display("%0d spare-action beats ignored, %0d output bytes compared", n_spare,
               bytes_checked);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
